// File: sv/sem_pkg.sv
package sem_pkg;

   localparam int PIX_W   = 8;    // color component and luma
   localparam int DIM_W   = 13;   // frame_width / frame_height registers
   localparam int COORD_W = 12;   // emitted coordinates
   localparam int SUM_W   = 18;   // 299R + 587G + 114B, at most 255000
   localparam int RECIP_W = 19;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam int GRAD_W  = 11;   // signed Sobel gradient, |g| <= 1020
   localparam int SQ_W    = 21;   // gx^2 + gy^2 <= 2080800
   localparam int REM_W   = 11;
   localparam int LINE_W  = 2 * PIX_W;

   // floor(s / 1000) == (s * ceil(2^28 / 1000)) >> 28 for every s below 2^18
   localparam logic [RECIP_W-1:0] LUMA_RECIP = 19'd268436;
   localparam int LUMA_SHIFT = 28;

   localparam logic [DIM_W-1:0] DIM_MIN    = 13'd3;
   localparam logic [DIM_W-1:0] HEIGHT_CAP = 13'd4096;
   localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 3'h0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 3'h4;

   typedef struct packed {
      logic               emit;
      logic               last;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } pos_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [PIX_W-1:0] root;
   } sqrt_type;

   // one digit of the restoring square root: bring down two radicand bits
   function automatic sqrt_type sqrt_step(sqrt_type cur, logic [1:0] pair);
      logic [REM_W-1:0] rem_s;
      logic [REM_W-1:0] trial;
      sqrt_type nxt;
      rem_s = {cur.rem[REM_W-3:0], pair};
      trial = {1'b0, cur.root, 2'b01};
      if (rem_s >= trial) begin
         nxt.rem  = rem_s - trial;
         nxt.root = {cur.root[PIX_W-2:0], 1'b1};
      end else begin
         nxt.rem  = rem_s;
         nxt.root = {cur.root[PIX_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

// File: sv/sem_line_buf.sv
module sem_line_buf
   import sem_pkg::*;
#(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [LINE_W-1:0] wr_data,
   output logic [LINE_W-1:0] rd_data
);

   // each entry: {older line luma, previous line luma}
   logic [LINE_W-1:0] mem_ff [DEPTH];
   logic [LINE_W-1:0] rd_q_ff;
   logic [LINE_W-1:0] fwd_data_ff;
   logic              fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff     <= mem_ff[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   // same entry written in the read cycle: take the new data
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_q_ff;

endmodule

// File: sv/sem_front.sv
module sem_front
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = 4096,
   parameter int ADDR_W    = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              accept,
   input  logic [PIX_W-1:0]  red,
   input  logic [PIX_W-1:0]  green,
   input  logic [PIX_W-1:0]  blue,
   input  logic              start_of_frame,
   input  logic [DIM_W-1:0]  frame_width,
   input  logic [DIM_W-1:0]  frame_height,
   output logic [ADDR_W-1:0] rd_addr,
   output logic              valid1,
   output logic [ADDR_W-1:0] addr1,
   output logic [SUM_W-1:0]  sum1,
   output pos_type           pos1
);

   localparam int WIDTH_CAP = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;

   logic [DIM_W-1:0]   col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0]   eff_w, eff_h;
   logic [DIM_W-1:0]   cur_c, cur_r, nxt_r;
   logic [SUM_W-1:0]   sum;
   pos_type            pos;

   logic               valid1_ff;
   logic [ADDR_W-1:0]  addr1_ff;
   logic [SUM_W-1:0]   sum1_ff;
   pos_type            pos1_ff;

   always_comb begin
      eff_w = frame_width;
      if (frame_width < DIM_MIN) begin
         eff_w = DIM_MIN;
      end else if (frame_width > DIM_W'(WIDTH_CAP)) begin
         eff_w = DIM_W'(WIDTH_CAP);
      end
      eff_h = frame_height;
      if (frame_height < DIM_MIN) begin
         eff_h = DIM_MIN;
      end else if (frame_height > HEIGHT_CAP) begin
         eff_h = HEIGHT_CAP;
      end
   end

   // position of this pixel, wrapping when the geometry shrank
   always_comb begin
      cur_c = start_of_frame ? '0 : col_ff;
      cur_r = start_of_frame ? '0 : {1'b0, row_ff};
      if (cur_c >= eff_w) begin
         cur_c = '0;
         cur_r = cur_r + 1'b1;
      end
      if (cur_r >= eff_h) begin
         cur_r = '0;
      end
      col_in = cur_c + 1'b1;
      nxt_r  = cur_r;
      if (col_in >= eff_w) begin
         col_in = '0;
         nxt_r  = cur_r + 1'b1;
         if (nxt_r >= eff_h) begin
            nxt_r = '0;
         end
      end
      row_in = nxt_r[COORD_W-1:0];
   end

   always_comb begin
      pos.emit = (cur_c >= DIM_W'(2)) && (cur_r >= DIM_W'(2));
      pos.last = (cur_c == eff_w - 1'b1) && (cur_r == eff_h - 1'b1);
      pos.col  = COORD_W'(cur_c - 1'b1);
      pos.row  = COORD_W'(cur_r - 1'b1);
   end

   assign sum = ({10'd0, red}   * 18'd299)
              + ({10'd0, green} * 18'd587)
              + ({10'd0, blue}  * 18'd114);

   assign rd_addr = ADDR_W'(cur_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         valid1_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (adv) begin
            valid1_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr1_ff <= rd_addr;
         sum1_ff  <= sum;
         pos1_ff  <= pos;
      end
   end

   assign valid1 = valid1_ff;
   assign addr1  = addr1_ff;
   assign sum1   = sum1_ff;
   assign pos1   = pos1_ff;

endmodule

// File: sv/sem_window.sv
module sem_window
   import sem_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              valid1,
   input  logic [SUM_W-1:0]  sum1,
   input  pos_type           pos1,
   input  logic [LINE_W-1:0] line_rd,
   output logic              wr_en,
   output logic [LINE_W-1:0] wr_data,
   output logic              valid3,
   output logic [SQ_W-1:0]   sumsq3,
   output pos_type           pos3
);

   logic [PROD_W-1:0] prod;
   logic [PIX_W-1:0]  luma;
   logic [PIX_W-1:0]  win_ff [9];
   logic [PIX_W-1:0]  win_in [9];

   logic              valid2_ff;
   pos_type           pos2_ff;

   logic [9:0]          px, nx, py, ny;
   logic signed [GRAD_W-1:0] gx, gy;
   logic signed [2*GRAD_W-1:0] sqx, sqy;
   logic [SQ_W-1:0]     sumsq;

   logic                valid3_ff;
   logic [SQ_W-1:0]     sumsq3_ff;
   pos_type             pos3_ff;

   assign prod = {{RECIP_W{1'b0}}, sum1} * {{SUM_W{1'b0}}, LUMA_RECIP};
   assign luma = prod[LUMA_SHIFT +: PIX_W];

   // line entry moves down: previous becomes older, new luma becomes previous
   assign wr_en   = adv && valid1;
   assign wr_data = {line_rd[PIX_W-1:0], luma};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k*3]     = win_ff[k*3 + 1];
         win_in[k*3 + 1] = win_ff[k*3 + 2];
      end
      win_in[2] = line_rd[LINE_W-1:PIX_W];
      win_in[5] = line_rd[PIX_W-1:0];
      win_in[8] = luma;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (adv) begin
         if (valid1) begin
            win_ff <= win_in;
         end
         valid2_ff <= valid1 && pos1.emit;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos2_ff   <= pos1;
         sumsq3_ff <= sumsq;
         pos3_ff   <= pos2_ff;
      end
   end

   // Sobel taps on the window of the item held in stage two
   always_comb begin
      px = {2'b0, win_ff[2]} + {1'b0, win_ff[5], 1'b0} + {2'b0, win_ff[8]};
      nx = {2'b0, win_ff[0]} + {1'b0, win_ff[3], 1'b0} + {2'b0, win_ff[6]};
      py = {2'b0, win_ff[6]} + {1'b0, win_ff[7], 1'b0} + {2'b0, win_ff[8]};
      ny = {2'b0, win_ff[0]} + {1'b0, win_ff[1], 1'b0} + {2'b0, win_ff[2]};
      gx = $signed({1'b0, px}) - $signed({1'b0, nx});
      gy = $signed({1'b0, py}) - $signed({1'b0, ny});
      sqx = gx * gx;
      sqy = gy * gy;
      sumsq = sqx[SQ_W-1:0] + sqy[SQ_W-1:0];
   end

   assign valid3 = valid3_ff;
   assign sumsq3 = sumsq3_ff;
   assign pos3   = pos3_ff;

endmodule

// File: sv/sem_sqrt.sv
module sem_sqrt
   import sem_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             valid3,
   input  logic [SQ_W-1:0]  sumsq3,
   input  pos_type          pos3,
   output logic             res_valid,
   output logic [PIX_W-1:0] res_mag,
   output pos_type          res_pos
);

   sqrt_type         hi_part, lo_part;
   logic             sat;

   logic             valid4_ff;
   sqrt_type         part_ff;
   logic [PIX_W-1:0] low_ff;
   logic             sat_ff;
   pos_type          pos4_ff;

   // anything at or above 256^2 clamps to 255
   assign sat = |sumsq3[SQ_W-1:2*PIX_W];

   always_comb begin
      hi_part = '0;
      for (int i = 3; i >= 0; i--) begin
         hi_part = sqrt_step(hi_part, sumsq3[PIX_W + 2*i +: 2]);
      end
   end

   always_comb begin
      lo_part = part_ff;
      for (int i = 3; i >= 0; i--) begin
         lo_part = sqrt_step(lo_part, low_ff[2*i +: 2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
      end else if (adv) begin
         valid4_ff <= valid3;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         part_ff <= hi_part;
         low_ff  <= sumsq3[PIX_W-1:0];
         sat_ff  <= sat;
         pos4_ff <= pos3;
      end
   end

   assign res_valid = valid4_ff;
   assign res_mag   = sat_ff ? {PIX_W{1'b1}} : lo_part.root;
   assign res_pos   = pos4_ff;

endmodule

// File: sv/sobel_edge_magnitude_top.sv
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready   tdata: red, green, blue; tuser: start_of_frame
// rsp       out        rsp_tvalid/rsp_tready   tdata: column, row, magnitude; tlast: last_of_frame
// csr       in/out     APB psel/penable        frame_width @0x0, frame_height @0x4
//
// One pixel is taken per clock while the result side keeps up; each result is registered
// in the front, window, Sobel, square-root and result stages. The line memory takes one
// read at accept and one write as the pixel leaves the front register, forwarding the
// write when both hit the same entry, so back-to-back pixels never wait on it. Reset
// clears the counters, the window and all valid flags; the line memory is not cleared.
// A stall on rsp holds every stage, and req_tready drops with it.
module sobel_edge_magnitude_top
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // red[7:0], green[15:8], blue[23:16]
   input  logic                  req_tuser,   // start_of_frame
   // edge results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // column[11:0], row[23:12], magnitude[31:24]
   output logic                  rsp_tlast,   // last_of_frame
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [DIM_W-1:0] width_ff, height_ff;
   logic             csr_write;

   logic              adv, accept;
   logic [ADDR_W-1:0] rd_addr, addr1;
   logic              valid1;
   logic [SUM_W-1:0]  sum1;
   pos_type           pos1;
   logic [LINE_W-1:0] line_rd;
   logic              wr_en;
   logic [LINE_W-1:0] wr_data;
   logic              valid3;
   logic [SQ_W-1:0]   sumsq3;
   pos_type           pos3;
   logic              res_valid;
   logic [PIX_W-1:0]  res_mag;
   pos_type           res_pos;

   logic              rsp_valid_ff;
   logic [31:0]       rsp_data_ff;
   logic              rsp_last_ff;

   // --- configuration registers: decode on the word address bit
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else if (csr_write) begin
         if (csr_paddr[2] == CSR_FRAME_HEIGHT[2]) begin
            height_ff <= csr_pwdata[DIM_W-1:0];
         end else begin
            width_ff <= csr_pwdata[DIM_W-1:0];
         end
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_FRAME_WIDTH[2]:  csr_prdata = {{(32-DIM_W){1'b0}}, width_ff};
         CSR_FRAME_HEIGHT[2]: csr_prdata = {{(32-DIM_W){1'b0}}, height_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // --- pipeline advance: move everything unless the result register is stuck
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   sem_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADDR_W    (ADDR_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .accept         (accept),
      .red            (req_tdata[7:0]),
      .green          (req_tdata[15:8]),
      .blue           (req_tdata[23:16]),
      .start_of_frame (req_tuser),
      .frame_width    (width_ff),
      .frame_height   (height_ff),
      .rd_addr        (rd_addr),
      .valid1         (valid1),
      .addr1          (addr1),
      .sum1           (sum1),
      .pos1           (pos1)
   );

   // line memory: read at accept, written back as the pixel leaves the front register
   sem_line_buf #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (addr1),
      .wr_data (wr_data),
      .rd_data (line_rd)
   );

   sem_window u_window (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .valid1  (valid1),
      .sum1    (sum1),
      .pos1    (pos1),
      .line_rd (line_rd),
      .wr_en   (wr_en),
      .wr_data (wr_data),
      .valid3  (valid3),
      .sumsq3  (sumsq3),
      .pos3    (pos3)
   );

   sem_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .valid3    (valid3),
      .sumsq3    (sumsq3),
      .pos3      (pos3),
      .res_valid (res_valid),
      .res_mag   (res_mag),
      .res_pos   (res_pos)
   );

   // --- result register: load on advance, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && res_valid) begin
         rsp_data_ff <= {res_mag, res_pos.row, res_pos.col};
         rsp_last_ff <= res_pos.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
